@@ design/page_polynomial_hash_update_unit_assert.svh @@
// assertion macros for the polynomial page hash update unit
// used by the checker; needs clk and rst_n in scope
`ifndef PAGE_POLYNOMIAL_HASH_UPDATE_UNIT_ASSERT_SVH
`define PAGE_POLYNOMIAL_HASH_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define PPHU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pphu check failed");

// next-cycle implication
`define PPHU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pphu check failed");

`endif

@@ design/pphu_pkg.sv @@
// shared constants and the mod 2^61-1 fold for the page hash update unit
// no dependencies
package pphu_pkg;

    localparam int HASH_W = 61;
    localparam int IDX_W = 16;
    localparam int BYTE_W = 8;
    localparam int DEFAULT_PAGE_BYTES = 4096;
    localparam logic [HASH_W-1:0] MOD61 = {HASH_W{1'b1}};
    localparam logic [HASH_W-1:0] BASE_RESET = 61'd131;

    // reduce a value below 2^62 into [0, M), using 2^61 = 1 mod M
    function automatic logic [HASH_W-1:0] fold62(input logic [HASH_W:0] x);
        logic [HASH_W:0] y;
        y = {1'b0, x[HASH_W-1:0]} + {{HASH_W{1'b0}}, x[HASH_W]};
        if (y >= {1'b0, MOD61})
        begin
            y = y - {1'b0, MOD61};
        end
        return y[HASH_W-1:0];
    endfunction

endpackage

@@ design/pphu_mulmod.sv @@
// multi-cycle modular multiplier mod 2^61-1 on one 32x32 multiplier
// depends on pphu_pkg
module pphu_mulmod
    import pphu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] a,
    input  logic [HASH_W-1:0] b,
    output logic              done,
    output logic [HASH_W-1:0] prod
);

    localparam int ACC_W = 2 * HASH_W;

    logic [HASH_W-1:0] a_reg;
    logic [HASH_W-1:0] b_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [1:0]        k_reg;
    logic              run_reg;
    logic              fold_reg;
    logic              done_reg;
    logic [HASH_W-1:0] prod_reg;
    logic [31:0]       a_half;
    logic [31:0]       b_half;
    logic [63:0]       pp;
    logic [ACC_W-1:0]  pp_shift;
    logic [HASH_W:0]   acc_sum;

    // one partial product per cycle: a0*b0, a0*b1, a1*b0, a1*b1
    always_comb
    begin
        a_half = k_reg[1] ? {3'b0, a_reg[HASH_W-1:32]} : a_reg[31:0];
        b_half = k_reg[0] ? {3'b0, b_reg[HASH_W-1:32]} : b_reg[31:0];
        pp = a_half * b_half;
        case (k_reg)
            2'd0:    pp_shift = {{(ACC_W-64){1'b0}}, pp};
            2'd3:    pp_shift = {pp[ACC_W-65:0], 64'b0};
            default: pp_shift = {{(ACC_W-96){1'b0}}, pp, 32'b0};
        endcase
        acc_next = acc_reg + pp_shift;
        acc_sum = {1'b0, acc_reg[HASH_W-1:0]} + {1'b0, acc_reg[ACC_W-1:HASH_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fold_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                fold_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                if (k_reg == 2'd3)
                begin
                    run_reg  <= 1'b0;
                    fold_reg <= 1'b1;
                end
            end
            else if (fold_reg)
            begin
                fold_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            k_reg   <= 2'd0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            k_reg   <= k_reg + 2'd1;
        end
        if (fold_reg)
        begin
            prod_reg <= fold62(acc_sum);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ design/page_polynomial_hash_update_unit.sv @@
// each modular square or multiply runs on the shared 32x32 multiplier; out-of-range indexes
// and unchanged bytes skip the power and delta steps and go straight to the output state
// one item at a time: s_tready rises together with m_tvalid, when the result is registered
// reset: asynchronous active low; clears running hash to zero and base to 131
module page_polynomial_hash_update_unit
    import pphu_pkg::*;
#(
    parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [HASH_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // hash_in[60:0], byte_index[76:61], old_byte[84:77], new_byte[92:85], zero fill
    input  logic [95:0]       s_tdata,
    // func
    input  logic              s_tuser,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // hash_out[60:0], zero fill
    output logic [63:0]       m_tdata,
    // index_error
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int EXP_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int CNT_W = $clog2(EXP_W + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_STEP     = 8'b00000010,
        S_SQR_WAIT = 8'b00000100,
        S_MUL_GO   = 8'b00001000,
        S_MUL_WAIT = 8'b00010000,
        S_DELTA    = 8'b00100000,
        S_APPLY    = 8'b01000000,
        S_OUT      = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [HASH_W-1:0] base_reg, base_next;
    logic [HASH_W-1:0] running_reg, running_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [HASH_W-1:0] h_reg, h_next;
    logic              err_reg, err_next;
    logic              last_reg, last_next;
    logic [BYTE_W-1:0] old_reg, old_next;
    logic [BYTE_W-1:0] new_reg, new_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              one_reg, one_next;
    logic [HASH_W-1:0] r_reg, r_next;
    logic [HASH_W-1:0] dfold_reg, dfold_next;
    logic              neg_reg, neg_next;
    logic [HASH_W-1:0] hout_reg, hout_next;
    logic              eout_reg, eout_next;
    logic              lout_reg, lout_next;

    logic [HASH_W-1:0] in_hash;
    logic [IDX_W-1:0]  in_idx;
    logic [BYTE_W-1:0] in_old;
    logic [BYTE_W-1:0] in_new;
    logic              accept;
    logic              idx_bad;
    logic              mm_start;
    logic [HASH_W-1:0] mm_b;
    logic              mm_done;
    logic [HASH_W-1:0] mm_prod;
    logic [BYTE_W-1:0] dmag;
    logic [HASH_W+BYTE_W-1:0] dprod;
    logic [HASH_W:0]   dsum;
    logic [HASH_W:0]   sum_pos;
    logic [HASH_W:0]   diff;
    logic [HASH_W:0]   diff_wrap;
    logic [HASH_W-1:0] h_applied;
    logic              out_free;

    assign in_hash = s_tdata[60:0];
    assign in_idx  = s_tdata[76:61];
    assign in_old  = s_tdata[84:77];
    assign in_new  = s_tdata[92:85];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign idx_bad  = (in_idx >= IDX_W'(PAGE_BYTES));
    assign out_free = !m_tvalid_reg || m_tready;

    assign mm_start = ((state_reg == S_STEP) && (cnt_reg != '0) && !one_reg)
                      || (state_reg == S_MUL_GO);
    assign mm_b = (state_reg == S_MUL_GO) ? base_reg : r_reg;

    pphu_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (r_reg),
        .b     (mm_b),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    // (new - old) * B^index as magnitude and sign, then add or subtract mod M
    always_comb
    begin
        dmag = (new_reg >= old_reg) ? (new_reg - old_reg) : (old_reg - new_reg);
        dprod = dmag * r_reg;
        dsum = {1'b0, dprod[HASH_W-1:0]}
               + {{(HASH_W+1-BYTE_W){1'b0}}, dprod[HASH_W+BYTE_W-1:HASH_W]};
        sum_pos = {1'b0, h_reg} + {1'b0, dfold_reg};
        diff = {1'b0, h_reg} - {1'b0, dfold_reg};
        diff_wrap = diff + {1'b0, MOD61};
        if (!neg_reg)
        begin
            h_applied = fold62(sum_pos);
        end
        else if (h_reg >= dfold_reg)
        begin
            h_applied = diff[HASH_W-1:0];
        end
        else
        begin
            h_applied = diff_wrap[HASH_W-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        running_next  = running_reg;
        m_tvalid_next = m_tvalid_reg;
        h_next        = h_reg;
        err_next      = err_reg;
        last_next     = last_reg;
        old_next      = old_reg;
        new_next      = new_reg;
        exp_next      = exp_reg;
        cnt_next      = cnt_reg;
        one_next      = one_reg;
        r_next        = r_reg;
        dfold_next    = dfold_reg;
        neg_next      = neg_reg;
        hout_next     = hout_reg;
        eout_next     = eout_reg;
        lout_next     = lout_reg;

        if (cfg_we)
        begin
            base_next = fold62({1'b0, cfg_wdata});
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    h_next    = s_tuser ? fold62({1'b0, in_hash}) : running_reg;
                    err_next  = idx_bad;
                    last_next = s_tlast;
                    old_next  = in_old;
                    new_next  = in_new;
                    exp_next  = in_idx[EXP_W-1:0];
                    cnt_next  = CNT_W'(EXP_W);
                    one_next  = 1'b1;
                    r_next    = {{(HASH_W-1){1'b0}}, 1'b1};
                    if (idx_bad || (in_old == in_new))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DELTA;
                end
                else if (one_reg)
                begin
                    // squaring 1 is a no-op, and 1 * B is just B
                    if (exp_reg[EXP_W-1])
                    begin
                        r_next   = base_reg;
                        one_next = 1'b0;
                    end
                    exp_next = exp_reg << 1;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = S_SQR_WAIT;
                end
            end
            S_SQR_WAIT:
            begin
                if (mm_done)
                begin
                    r_next = mm_prod;
                    if (exp_reg[EXP_W-1])
                    begin
                        state_next = S_MUL_GO;
                    end
                    else
                    begin
                        exp_next   = exp_reg << 1;
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_STEP;
                    end
                end
            end
            S_MUL_GO:
            begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mm_done)
                begin
                    r_next     = mm_prod;
                    exp_next   = exp_reg << 1;
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_STEP;
                end
            end
            S_DELTA:
            begin
                dfold_next = fold62(dsum);
                neg_next   = (old_reg > new_reg);
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                h_next     = h_applied;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    hout_next     = h_reg;
                    eout_next     = err_reg;
                    lout_next     = last_reg;
                    m_tvalid_next = 1'b1;
                    running_next  = h_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_reg     <= BASE_RESET;
            running_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            running_reg  <= running_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg     <= h_next;
        err_reg   <= err_next;
        last_reg  <= last_next;
        old_reg   <= old_next;
        new_reg   <= new_next;
        exp_reg   <= exp_next;
        cnt_reg   <= cnt_next;
        one_reg   <= one_next;
        r_reg     <= r_next;
        dfold_reg <= dfold_next;
        neg_reg   <= neg_next;
        hout_reg  <= hout_next;
        eout_reg  <= eout_next;
        lout_reg  <= lout_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b0, hout_reg};
    assign m_tuser  = eout_reg;
    assign m_tlast  = lout_reg;

endmodule

@@ design/pphu_checker.sv @@
// port-level checks for the page hash update unit, bound to the top level
// depends on page_polynomial_hash_update_unit_assert.svh
`include "page_polynomial_hash_update_unit_assert.svh"

module pphu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // one item in flight: the input side closes right after an item is taken
    `PPHU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // result is fully reduced and the fill bits stay zero
    `PPHU_ASSERT_NOW(a_hash_reduced, m_tvalid, (~&m_tdata[60:0]) && (m_tdata[63:61] == 3'b0))

    `PPHU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an idle unit with nothing offered raises no result
    `PPHU_ASSERT_NEXT(a_no_spurious_out, !m_tvalid && s_tready && !s_tvalid, !m_tvalid)

endmodule

bind page_polynomial_hash_update_unit pphu_checker u_pphu_checker (.*);

@@ bench/page_polynomial_hash_update_unit_test.sv @@
// testbench for the polynomial page hash update unit: directed and random byte changes,
// checked against a mod 2^61-1 hash predictor kept in the bench
// depends on pphu_pkg and page_polynomial_hash_update_unit
module page_polynomial_hash_update_unit_test;
    import pphu_pkg::*;

    localparam int PAGE_LEN = DEFAULT_PAGE_BYTES;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [HASH_W-1:0] hash;
        logic              err;
        logic              last;
    } hash_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [HASH_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // hash_in[60:0], byte_index[76:61], old_byte[84:77], new_byte[92:85], zero fill
    logic [95:0]       s_tdata = '0;
    // func
    logic              s_tuser = 1'b0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // hash_out[60:0], zero fill
    logic [63:0]       m_tdata;
    // index_error
    logic              m_tuser;
    logic              m_tlast;

    // predictor state
    logic [HASH_W-1:0] model_base = BASE_RESET;
    logic [HASH_W-1:0] page_hash_now = '0;

    hash_result_t expected_hashes[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int sink_hold = 0;
    bit idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    page_polynomial_hash_update_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // v below 2^63; 2^61 = 1 mod M
    function automatic logic [HASH_W-1:0] reduce_mod(input logic [HASH_W+1:0] v);
        logic [HASH_W+1:0] t;
        t = {2'b00, v[HASH_W-1:0]} + {{HASH_W{1'b0}}, v[HASH_W+1:HASH_W]};
        if (t >= {2'b00, MOD61})
        begin
            t = t - {2'b00, MOD61};
        end
        return t[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] mul_mod(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [2*HASH_W-1:0] p;
        p = {{HASH_W{1'b0}}, a} * {{HASH_W{1'b0}}, b};
        return reduce_mod({2'b00, p[HASH_W-1:0]} + {2'b00, p[2*HASH_W-1:HASH_W]});
    endfunction

    function automatic logic [HASH_W-1:0] power_mod(input logic [HASH_W-1:0] b,
                                                    input logic [IDX_W-1:0] e);
        logic [HASH_W-1:0] r;
        r = {{(HASH_W-1){1'b0}}, 1'b1};
        for (int i = IDX_W - 1; i >= 0; i--)
        begin
            r = mul_mod(r, r);
            if (e[i])
            begin
                r = mul_mod(r, b);
            end
        end
        return r;
    endfunction

    function automatic hash_result_t predict_page_hash(input logic func,
                                                       input logic [HASH_W-1:0] start_hash,
                                                       input logic [IDX_W-1:0] pos,
                                                       input logic [BYTE_W-1:0] old_val,
                                                       input logic [BYTE_W-1:0] new_val,
                                                       input logic last);
        hash_result_t r;
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] weight;
        logic [HASH_W-1:0] add_term;
        logic [HASH_W-1:0] sub_term;
        h = func ? reduce_mod({2'b00, start_hash}) : page_hash_now;
        r.err = (pos >= PAGE_LEN);
        if (!r.err)
        begin
            weight = power_mod(reduce_mod({2'b00, model_base}), pos);
            add_term = mul_mod({{(HASH_W-BYTE_W){1'b0}}, new_val}, weight);
            sub_term = mul_mod({{(HASH_W-BYTE_W){1'b0}}, old_val}, weight);
            h = reduce_mod({2'b00, h} + {2'b00, add_term} + {2'b00, MOD61 - sub_term});
        end
        page_hash_now = h;
        r.hash = h;
        r.last = last;
        return r;
    endfunction

    function automatic logic [HASH_W-1:0] random_hash();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0)
        begin
            r[HASH_W-1:0] = MOD61;
        end
        return r[HASH_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        logic [IDX_W-1:0] pos;
        case ($urandom_range(0, 11))
            0: pos = IDX_W'($urandom_range(0, 65535));
            1: pos = IDX_W'($urandom_range(PAGE_LEN - 2, PAGE_LEN + 1));
            2: pos = IDX_W'($urandom_range(0, 3));
            default: pos = IDX_W'($urandom_range(0, PAGE_LEN - 1));
        endcase
        return pos;
    endfunction

    function automatic logic [HASH_W-1:0] random_base();
        logic [HASH_W-1:0] b;
        case ($urandom_range(0, 5))
            0: b = BASE_RESET;
            1: b = HASH_W'(2);
            2: b = MOD61 - HASH_W'(1);
            default: b = random_hash();
        endcase
        return b;
    endfunction

    task automatic send_change(input logic func, input logic [HASH_W-1:0] start_hash,
                               input logic [IDX_W-1:0] pos, input logic [BYTE_W-1:0] old_val,
                               input logic [BYTE_W-1:0] new_val, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, new_val, old_val, pos, start_hash};
        s_tuser <= func;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_hashes.push_back(predict_page_hash(func, start_hash, pos, old_val, new_val,
                                                    last));
        items_sent++;
    endtask

    // always advances at least one edge so valid is never lowered and raised in one step
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_hashes.size() != 0);
    endtask

    task automatic write_base(input logic [HASH_W-1:0] value);
        wait_results_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_base = value;
    endtask

    // one run of byte changes; mostly well formed, with some broken items mixed in
    task automatic run_page_updates(input bit full_page);
        int len;
        bit noise;
        logic [HASH_W-1:0] start;
        len = $urandom_range(1, 12);
        idle_on = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        start = full_page ? '0 : random_hash();
        for (int k = 0; k < len; k++)
        begin
            noise = ($urandom_range(0, 9) == 0);
            send_change((k == 0) || (noise && $urandom_range(0, 1)),
                        noise ? random_hash() : start,
                        random_index(),
                        (full_page && !noise) ? 8'd0 : 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)),
                        noise ? 1'($urandom_range(0, 1)) : (k == len - 1));
        end
    endtask

    task automatic test_reset_base();
        idle_on = 1'b1;
        send_change(1'b1, '0, IDX_W'(0), 8'd0, 8'd255, 1'b0);
        send_change(1'b0, '0, IDX_W'(1), 8'd0, 8'd1, 1'b0);
        send_change(1'b0, '0, IDX_W'(PAGE_LEN - 1), 8'd0, 8'd128, 1'b0);
        // out of page leaves the hash alone
        send_change(1'b0, '0, IDX_W'(PAGE_LEN), 8'd3, 8'd9, 1'b0);
        send_change(1'b0, MOD61, 16'hffff, 8'd255, 8'd0, 1'b1);
        // start value equal to the modulus acts as zero
        send_change(1'b1, MOD61, IDX_W'(7), 8'd255, 8'd0, 1'b0);
        // unchanged byte passes the hash through
        send_change(1'b1, MOD61 - HASH_W'(1), IDX_W'(PAGE_LEN / 2), 8'd42, 8'd42, 1'b0);
        send_change(1'b0, '0, IDX_W'(0), 8'd255, 8'd255, 1'b1);
        send_change(1'b1, MOD61 - HASH_W'(1), 16'hffff, 8'd0, 8'd0, 1'b0);
        send_change(1'b1, MOD61, IDX_W'(PAGE_LEN), 8'd1, 8'd2, 1'b1);
        send_change(1'b0, '0, IDX_W'(3), 8'd0, 8'd0, 1'b1);
    endtask

    task automatic test_base_extremes();
        logic [HASH_W-1:0] bases[5];
        bases = '{'0, HASH_W'(1), MOD61, HASH_W'(2), MOD61 - HASH_W'(1)};
        foreach (bases[i])
        begin
            write_base(bases[i]);
            send_change(1'b1, random_hash(), IDX_W'(0), 8'd0, 8'd200, 1'b0);
            send_change(1'b0, '0, IDX_W'(PAGE_LEN - 1), 8'd17, 8'd255, 1'b1);
        end
    endtask

    task automatic test_full_page_runs(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            run_page_updates(1'b1);
        end
    endtask

    task automatic test_stream_updates(input int n_phases, input int phase_items);
        int stop_at;
        for (int p = 0; p < n_phases; p++)
        begin
            write_base(random_base());
            stop_at = items_sent + phase_items;
            while (items_sent < stop_at)
            begin
                run_page_updates(1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_backpressure(input int n_items);
        int stop_at;
        wait_results_drained();
        sink_hold = HOLD_CYCLES;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            run_page_updates(1'b0);
            idle_on = 1'b0;
        end
        // sender waits for every result before going on
        wait_results_drained();
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            run_page_updates(1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            else if (m_tready && m_tvalid)
            begin
                stall = sink_idle_on ? $urandom_range(0, 7) : 0;
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        hash_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hashes.size() == 0)
            begin
                $error("unexpected result: hash_out %h", m_tdata[HASH_W-1:0]);
                mismatch_count++;
            end
            else
            begin
                want = expected_hashes.pop_front();
                if (m_tdata[HASH_W-1:0] !== want.hash)
                begin
                    $error("hash_out: expected %h, got %h", want.hash, m_tdata[HASH_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.err)
                begin
                    $error("index_error: expected %b, got %b", want.err, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_out: expected %b, got %b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_base();
        test_base_extremes();
        test_full_page_runs(200);
        test_stream_updates(5, 60);
        test_backpressure(25);
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_hashes.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
